>>> sv/ccab_pkg.sv
`default_nettype none
// ============================================================================
// ccab_pkg: shared types and constants of the carrier-sense backoff engine
// Field widths, sequencing limits, action codes and the controller command
// bundle used by the controller and the datapath.
// ============================================================================
package ccab_pkg;

    // sequencing limits
    localparam int MAX_ATTEMPTS = 3;
    localparam int ED_REREADS   = 4;

    // field widths
    localparam int ED_W   = 8;
    localparam int RND_W  = 16;
    localparam int ACT_W  = 3;
    localparam int BO_W   = 14;
    localparam int VS_W   = 2;

    // derived state widths
    localparam int ATT_W   = $clog2(MAX_ATTEMPTS + 1);
    localparam int CNT_W   = $clog2(MAX_ATTEMPTS + 1);
    localparam int RI_W    = $clog2(ED_REREADS + 1);
    localparam int SUM_W   = ED_W + CNT_W;

    // mean: magnitude times ceil(2^DIV_K / count), exact for SUM_W-bit magnitudes
    localparam int DIV_K   = SUM_W + CNT_W;
    localparam int RECIP_W = DIV_K + 1;
    localparam int MPROD_W = SUM_W + RECIP_W;

    // backoff: random_word mod 100 by reciprocal, exact over 16 bits
    localparam int SLOT_MODULUS = 100;
    localparam int SLOT_US      = 100;
    localparam int RND_RECIP    = 83887;
    localparam int RND_SHIFT    = 23;
    localparam int RECIP_RND_W  = 17;
    localparam int QPROD_W      = RND_W + RECIP_RND_W;
    localparam int QUO_W        = QPROD_W - RND_SHIFT;
    localparam int REM_W        = 7;

    // reading that marks an invalid measurement, and the threshold reset value
    localparam logic signed [ED_W-1:0] ED_INVALID    = 8'sd127;
    localparam logic signed [ED_W-1:0] THRESHOLD_RST = -8'sd80;

    // start command value; any other cmd value is a reading
    localparam logic CMD_START = 1'b0;

    // result action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_MEASURE = 3'd0,
        ACT_REREAD  = 3'd1,
        ACT_BACKOFF = 3'd2,
        ACT_CLEAR   = 3'd3,
        ACT_BUSY    = 3'd4,
        ACT_IGNORED = 3'd5
    } action_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic eval;
        logic rem;
        logic load_out;
    } ccab_ctl_t;

endpackage
`default_nettype wire

>>> sv/ccab_ctrl.sv
`default_nettype none
// ============================================================================
// ccab_ctrl: request sequencer of the carrier-sense backoff engine
// Steps each request through capture, evaluate, remainder and output load,
// and owns the input ready and the output valid flag.
// ============================================================================
module ccab_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    output ccab_pkg::ccab_ctl_t  ctl
);
    import ccab_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_REM  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                ctl.eval   = 1'b1;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                ctl.rem    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait here while the output register still holds a result that out_ready has not taken
                if (!out_valid_reg || out_ready)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        if (ctl.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> sv/ccab_datapath.sv
`default_nettype none
// ============================================================================
// ccab_datapath: assessment state, sample averaging and backoff arithmetic
// Holds the threshold register, the operation state, the captured request,
// the reciprocal multipliers for mean and slot count, and the output register.
// ============================================================================
module ccab_datapath (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  ccab_pkg::ccab_ctl_t                    ctl,
    input  wire                                    cfg_valid,
    input  wire  signed [ccab_pkg::ED_W-1:0]       cfg_data,
    input  wire                                    cmd,
    input  wire  signed [ccab_pkg::ED_W-1:0]       ed_value,
    input  wire         [ccab_pkg::RND_W-1:0]      random_word,
    output logic        [ccab_pkg::ACT_W-1:0]      action,
    output logic        [ccab_pkg::BO_W-1:0]       backoff_us,
    output logic signed [ccab_pkg::ED_W-1:0]       mean_rssi,
    output logic        [ccab_pkg::VS_W-1:0]       valid_samples
);
    import ccab_pkg::*;

    // threshold register
    logic signed [ED_W-1:0] thr_reg;

    // operation state
    logic                    active_reg, active_next;
    logic [ATT_W-1:0]        att_reg, att_next;
    logic [RI_W-1:0]         ri_reg, ri_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    // captured request
    logic                    cmd_in_reg;
    logic signed [ED_W-1:0]  ed_in_reg;
    logic [RND_W-1:0]        rnd_in_reg;

    // evaluate stage results
    action_t                 act_reg, act_next;
    logic [CNT_W-1:0]        vs_reg, vs_next;
    logic                    neg_reg;
    logic [SUM_W-1:0]        mag_reg;
    logic [CNT_W-1:0]        div_reg;
    logic [QPROD_W-1:0]      qprod_reg;

    // remainder stage results
    logic [REM_W-1:0]        rem_reg;
    logic [MPROD_W-1:0]      mprod_reg;

    // evaluate helpers
    logic                    ed_ok;
    logic                    is_clear;
    logic signed [SUM_W-1:0] sum_add;
    logic [CNT_W-1:0]        cnt_add;
    logic [ATT_W-1:0]        att_dec;
    logic [SUM_W-1:0]        mag_next;

    // reciprocal table for the mean, one constant per sample count
    logic [RECIP_W-1:0]      recip_tab [2**CNT_W];

    assign recip_tab[0] = '0;
    for (genvar g = 1; g < 2**CNT_W; g++)
    begin : g_recip
        localparam logic [RECIP_W-1:0] RecipVal = RECIP_W'(((1 << DIV_K) + g - 1) / g);
        assign recip_tab[g] = RecipVal;
    end

    // threshold write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THRESHOLD_RST;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_in_reg <= cmd;
            ed_in_reg  <= ed_value;
            rnd_in_reg <= random_word;
        end
    end

    // assessment decision
    always_comb
    begin
        ed_ok    = (ed_in_reg != ED_INVALID);
        is_clear = ed_ok && (ed_in_reg < thr_reg);
        sum_add  = sum_reg + (ed_ok ? {{(SUM_W-ED_W){ed_in_reg[ED_W-1]}}, ed_in_reg}
                                    : SUM_W'(0));
        cnt_add  = cnt_reg + CNT_W'(ed_ok);
        att_dec  = (att_reg != '0) ? att_reg - ATT_W'(1) : att_reg;
        mag_next = sum_add[SUM_W-1] ? SUM_W'(-sum_add) : SUM_W'(sum_add);

        active_next = active_reg;
        att_next    = att_reg;
        ri_next     = ri_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        act_next    = ACT_IGNORED;
        vs_next     = '0;

        if (cmd_in_reg == CMD_START)
        begin
            active_next = 1'b1;
            att_next    = ATT_W'(MAX_ATTEMPTS);
            ri_next     = '0;
            sum_next    = '0;
            cnt_next    = '0;
            act_next    = ACT_MEASURE;
        end
        else if (!active_reg)
        begin
            act_next = ACT_IGNORED;
        end
        else if (ri_reg == '0)
        begin
            // first reading of each assessment is thrown away
            ri_next  = RI_W'(1);
            act_next = ACT_REREAD;
        end
        else if (!ed_ok && (ri_reg < RI_W'(ED_REREADS)))
        begin
            ri_next  = ri_reg + RI_W'(1);
            act_next = ACT_REREAD;
        end
        else
        begin
            // assessment complete
            sum_next = sum_add;
            cnt_next = cnt_add;
            att_next = att_dec;
            ri_next  = '0;
            if (is_clear)
            begin
                active_next = 1'b0;
                act_next    = ACT_CLEAR;
                vs_next     = cnt_add;
            end
            else if (att_dec != '0)
            begin
                act_next = ACT_BACKOFF;
            end
            else
            begin
                active_next = 1'b0;
                act_next    = ACT_BUSY;
                vs_next     = cnt_add;
            end
        end
    end

    // operation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            att_reg    <= '0;
            ri_reg     <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
        end
        else if (ctl.eval)
        begin
            active_reg <= active_next;
            att_reg    <= att_next;
            ri_reg     <= ri_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
        end
    end

    // evaluate stage: decision, mean operands, slot quotient product
    always_ff @(posedge clk)
    begin
        if (ctl.eval)
        begin
            act_reg   <= act_next;
            vs_reg    <= vs_next;
            neg_reg   <= sum_add[SUM_W-1];
            mag_reg   <= mag_next;
            div_reg   <= cnt_add;
            qprod_reg <= QPROD_W'(rnd_in_reg) * QPROD_W'(RND_RECIP);
        end
    end

    // remainder stage: slot remainder and scaled mean magnitude
    always_ff @(posedge clk)
    begin
        if (ctl.rem)
        begin
            rem_reg   <= REM_W'(rnd_in_reg
                         - RND_W'(qprod_reg[QPROD_W-1 -: QUO_W] * RND_W'(SLOT_MODULUS)));
            mprod_reg <= MPROD_W'(mag_reg) * MPROD_W'(recip_tab[div_reg]);
        end
    end

    // output register
    logic [ED_W-1:0] mean_mag;

    assign mean_mag = mprod_reg[DIV_K +: ED_W];

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            action        <= act_reg;
            valid_samples <= VS_W'(vs_reg);
            backoff_us    <= (act_reg == ACT_BACKOFF)
                             ? BO_W'(BO_W'(rem_reg) * BO_W'(SLOT_US)) : '0;
            if (act_reg == ACT_CLEAR)
                mean_rssi <= neg_reg ? $signed(ED_W'(0) - mean_mag) : $signed(mean_mag);
            else
                mean_rssi <= '0;
        end
    end

endmodule
`default_nettype wire

>>> sv/csma_cca_backoff_engine_top.sv
`default_nettype none
// ============================================================================
// csma_cca_backoff_engine_top: unslotted CSMA-CA carrier-sense sequencer
// Takes start commands and energy-detect readings, runs up to three clear
// channel assessments with random backoff, and reports clear/busy and mean.
// ============================================================================
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | cmd, ed_value, random_word
//  out     | out_valid / out_ready | action, backoff_us, mean_rssi,
//          |                       | valid_samples
//  cfg     | cfg_valid / cfg_ready | cfg_data (clear threshold, dBm)
//
//  Each request passes through capture, evaluate, remainder multiply and
//  output load, stepped by the controller state machine.
//  The result sits in an output register; the next request is taken while it
//  waits, and the output load stalls only when that register is still full.
//  cfg_ready is always high. Reset is asynchronous; the threshold resets to
//  -80 dBm and the operation state to idle.
//
module csma_cca_backoff_engine_top (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire                               cmd,
    input  wire  signed [ccab_pkg::ED_W-1:0]  ed_value,
    input  wire         [ccab_pkg::RND_W-1:0] random_word,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic        [ccab_pkg::ACT_W-1:0] action,
    output logic        [ccab_pkg::BO_W-1:0]  backoff_us,
    output logic signed [ccab_pkg::ED_W-1:0]  mean_rssi,
    output logic        [ccab_pkg::VS_W-1:0]  valid_samples,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  signed [ccab_pkg::ED_W-1:0]  cfg_data
);
    import ccab_pkg::*;

    ccab_ctl_t ctl;

    assign cfg_ready = 1'b1;

    // sequencer
    ccab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    // datapath
    ccab_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .ed_value      (ed_value),
        .random_word   (random_word),
        .action        (action),
        .backoff_us    (backoff_us),
        .mean_rssi     (mean_rssi),
        .valid_samples (valid_samples)
    );

    // a captured request blocks the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready while a request is in progress");

    // a loaded result sets valid and reopens the input for the next request
    a_load_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |=> out_valid && in_ready)
        else $error("result load did not set valid or return to idle");

    // backoff delay only on a backoff result
    a_backoff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action != ACT_BACKOFF) |-> backoff_us == '0)
        else $error("backoff delay on a non-backoff result");

    // mean only on a clear result
    a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action != ACT_CLEAR) |-> mean_rssi == '0)
        else $error("mean reported on a non-clear result");

endmodule
`default_nettype wire
